// File: hw/rtl/aes128_pkg.sv
// AES-128 shared types, S-box tables and round functions.
// Depends on nothing; used by the cipher core and its checker.
package aes128_pkg;

   localparam int NumPrep   = 10;
   localparam int NumRounds = 10;
   localparam int NumStages = NumPrep + NumRounds;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic        op;
      logic [63:0] block_hi;
      logic [63:0] block_lo;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
   } rsp_payload_type;

   // one pipeline beat: mode, state and the round key in hand
   typedef struct packed {
      logic         op;
      logic [127:0] st;
      logic [127:0] key;
   } stage_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // inverse table built at elaboration from the forward one
   function automatic sbox_table_type build_inv_sbox();
      sbox_table_type t;
      for (int j = 0; j < 256; j++) begin
         t[SBOX[j]] = j[7:0];
      end
      return t;
   endfunction

   localparam sbox_table_type INV_SBOX = build_inv_sbox();

   // round constants rc1 .. rc10
   typedef logic [7:0] rcon_table_type [NumRounds];
   localparam rcon_table_type RCON = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   // byte i of a state word, byte 0 in the top bits
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
      return s[127 - 8*i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // forward key schedule step
   function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] t, w0, w1, w2, w3;
      t  = {SBOX[get_byte(k, 13)] ^ rc, SBOX[get_byte(k, 14)],
            SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // undo one key schedule step
   function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] t, w0, w1, w2, w3;
      w3 = k[31:0] ^ k[63:32];
      w2 = k[63:32] ^ k[95:64];
      w1 = k[95:64] ^ k[127:96];
      t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = k[127:96] ^ t;
      return {w0, w1, w2, w3};
   endfunction

   // SubBytes after ShiftRows (they commute)
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*((c + r) % 4) + r) -: 8] = INV_SBOX[get_byte(s, 4*c + r)];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_fwd(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) a[r] = get_byte(s, 4*c + r);
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] = xtime(a[r]) ^ xtime(a[(r + 1) % 4])
               ^ a[(r + 1) % 4] ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_inv(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a [4];
      logic [7:0]   x2 [4];
      logic [7:0]   x4 [4];
      logic [7:0]   x8 [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a[r]  = get_byte(s, 4*c + r);
            x2[r] = xtime(a[r]);
            x4[r] = xtime(x2[r]);
            x8[r] = xtime(x4[r]);
         end
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(4*c + r) -: 8] =
                 (x8[r] ^ x4[r] ^ x2[r])
               ^ (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4])
               ^ (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4])
               ^ (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
         end
      end
      return t;
   endfunction

endpackage

// File: hw/rtl/aes128_block_cipher_core.sv
// AES-128 encrypt/decrypt core, one register stage per key step or round.
// Depends on aes128_pkg.
//
//   channel | dir | valid     | stall     | payload
//   req     | in  | req_valid | req_stall | req_data (op, block, key)
//   rsp     | out | rsp_valid | rsp_stall | rsp_data (result)
//
// The pipeline has ten key stages (forward expansion to the last round
// key for decrypt, pass-through for encrypt) and ten round stages.
// One beat enters per cycle while req_stall is low; each stage holds only when the one
// after it is full and held, so bubbles close up under a stall.
// Reset (synchronous) empties every stage; payload is not cleared.
module aes128_block_cipher_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  aes128_pkg::req_payload_type req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output aes128_pkg::rsp_payload_type rsp_data
);
   import aes128_pkg::*;

   stage_type stg_ff [NumStages];
   stage_type stg_in [NumStages];
   logic [NumStages-1:0] vld_ff;
   logic [NumStages:0]   adv;

   // a stage may load when it is empty or its content moves on
   assign adv[NumStages] = !rsp_stall;
   for (genvar i = 0; i < NumStages; i++) begin : g_adv
      assign adv[i] = !vld_ff[i] || adv[i+1];
   end
   assign req_stall = !adv[0];

   // stage logic
   for (genvar i = 0; i < NumStages; i++) begin : g_stage
      stage_type src;
      if (i == 0) begin : g_src_in
         assign src = '{op:  req_data.op,
                        st:  {req_data.block_hi, req_data.block_lo},
                        key: {req_data.key_hi, req_data.key_lo}};
      end else begin : g_src_prev
         assign src = stg_ff[i-1];
      end

      if (i < NumPrep) begin : g_prep
         // decrypt walks the schedule forward to the last round key
         always_comb begin
            stg_in[i] = src;
            if (src.op == OP_DECRYPT) begin
               stg_in[i].key = key_fwd(src.key, RCON[i]);
            end
         end
      end else begin : g_round
         localparam int J = i - NumPrep + 1;
         logic [127:0] st_pre;
         logic [127:0] nkey;
         logic [127:0] t;
         always_comb begin
            // first round also takes the initial whitening key
            st_pre = (J == 1) ? (src.st ^ src.key) : src.st;
            if (src.op == OP_ENCRYPT) begin
               nkey = key_fwd(src.key, RCON[J-1]);
               t    = sub_shift(st_pre);
               if (J < NumRounds) t = mix_fwd(t);
               t    = t ^ nkey;
            end else begin
               nkey = key_inv(src.key, RCON[NumRounds-J]);
               t    = inv_sub_shift(st_pre) ^ nkey;
               if (J < NumRounds) t = mix_inv(t);
            end
            stg_in[i] = '{op: src.op, st: t, key: nkey};
         end
      end

      always_ff @(posedge clock) begin
         if (adv[i]) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_valid;
         for (int i = 1; i < NumStages; i++) begin
            if (adv[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign rsp_valid = vld_ff[NumStages-1];
   assign rsp_data  = '{result_hi: stg_ff[NumStages-1].st[127:64],
                        result_lo: stg_ff[NumStages-1].st[63:0]};

endmodule

// File: hw/rtl/aes128_core_checker.sv
// Port-level checks for the AES-128 core, bound into the cipher core module.
// Depends on aes128_pkg.
module aes128_core_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input aes128_pkg::rsp_payload_type rsp_data
);
   import aes128_pkg::*;

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat present just after reset");

   // with nothing waiting at the output the input is never held
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output stage");

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result beat changed or vanished");

endmodule

bind aes128_block_cipher_core aes128_core_checker u_checker (.*);
